// File: rtl/core/fat12te_pkg.sv
// Shared widths, request codes and payload structs for the FAT12 table engine.
// No dependencies; every other file of the block refers to it by scoped names.
package fat12te_pkg;

   localparam int REQ_W         = 3;
   localparam int ADDR_W        = 13;
   localparam int BYTE_W        = 8;
   localparam int IDX_W         = 12;
   localparam int CNT_W         = 13;
   localparam int FREE_W        = 22;
   localparam int CLUSTER_SHIFT = 9;    // 512 bytes per cluster

   // entries_in_use after reset: floppy sector count less the reserved area
   localparam logic [CNT_W-1:0] ENTRIES_RESET = CNT_W'(2880 - 31);

   localparam logic [BYTE_W-1:0] LO_NIBBLE = 8'h0F;
   localparam logic [BYTE_W-1:0] HI_NIBBLE = 8'hF0;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD  = 3'd0,
      REQ_READ  = 3'd1,
      REQ_GET   = 3'd2,
      REQ_SET   = 3'd3,
      REQ_FIND  = 3'd4,
      REQ_COUNT = 3'd5
   } req_code_type;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [ADDR_W-1:0] byte_addr;
      logic [BYTE_W-1:0] byte_in;
      logic [IDX_W-1:0]  entry_index;
      logic [IDX_W-1:0]  entry_in;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]  entry_out;
      logic [BYTE_W-1:0] byte_out;
      logic [IDX_W-1:0]  free_index;
      logic              free_found;
      logic [FREE_W-1:0] free_bytes;
      logic              range_error;
   } rsp_payload_type;

   // one write port and one read port of the byte store
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// File: rtl/core/fat12te_if.sv
// Valid/ready channel interfaces for requests and responses of the table engine.
// Depends on fat12te_pkg for field widths.
interface fat12te_req_if;
   logic                              valid;
   logic                              ready;
   logic [fat12te_pkg::REQ_W-1:0]     req_type;
   logic [fat12te_pkg::ADDR_W-1:0]    byte_addr;
   logic [fat12te_pkg::BYTE_W-1:0]    byte_in;
   logic [fat12te_pkg::IDX_W-1:0]     entry_index;
   logic [fat12te_pkg::IDX_W-1:0]     entry_in;

   modport source (output valid, req_type, byte_addr, byte_in, entry_index, entry_in,
                   input ready);
   modport sink   (input valid, req_type, byte_addr, byte_in, entry_index, entry_in,
                   output ready);
endinterface

interface fat12te_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fat12te_pkg::IDX_W-1:0]     entry_out;
   logic [fat12te_pkg::BYTE_W-1:0]    byte_out;
   logic [fat12te_pkg::IDX_W-1:0]     free_index;
   logic                              free_found;
   logic [fat12te_pkg::FREE_W-1:0]    free_bytes;
   logic                              range_error;

   modport source (output valid, entry_out, byte_out, free_index, free_found, free_bytes,
                   range_error, input ready);
   modport sink   (input valid, entry_out, byte_out, free_index, free_found, free_bytes,
                   range_error, output ready);
endinterface

// File: rtl/core/fat12_table_engine_top.sv
// Top level of the FAT12 table engine: channels, entries_in_use register, output stage.
// Depends on fat12te_pkg, fat12te_if, fat12te_mem and fat12te_ctrl.
//
// Usage: one request transfer on req_ch gives exactly one response transfer on
// rsp_ch, in order. Requests: load byte, read byte, get entry, set entry, find
// free, count free. entries_in_use is written through csr_we/csr_wdata; the
// user must do so only while the block is idle, which the block does not enforce.
// Steps per request: load writes the byte; read byte reads it once; get entry
// reads both bytes; set entry reads the shared byte, then does two byte writes.
// Find free and count free stream the table one byte per cycle through the
// single read port over N entries (N is entries_in_use, capped by the table
// size; no read at all for N = 0); find free stops at the first zero entry.
// req_ch.ready is high whenever no request is in progress; it stays high
// while a finished response waits in the output register. When rsp_ch stalls,
// the next request is worked on and then held until the output register frees.
// Reset (synchronous) clears the sequencer and output valid and sets
// entries_in_use to 2849; table bytes are undefined until loaded.
module fat12_table_engine_top #(
   parameter int MAX_ENTRIES = 4096,
   parameter int TABLE_BYTES = 6144
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [fat12te_pkg::CNT_W-1:0]  csr_wdata,
   fat12te_req_if.sink                    req_ch,
   fat12te_rsp_if.source                  rsp_ch
);
   logic [fat12te_pkg::CNT_W-1:0]   entries_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   fat12te_pkg::rsp_payload_type    rsp_pl_ff;
   fat12te_pkg::req_payload_type    req_pl;
   fat12te_pkg::rsp_payload_type    res;
   fat12te_pkg::mem_req_type        mem_req;
   logic [fat12te_pkg::BYTE_W-1:0]  mem_rd_data;
   logic                            res_valid;
   logic                            out_free;
   logic                            req_ready;

   // request payload
   always_comb begin
      req_pl.req_type    = req_ch.req_type;
      req_pl.byte_addr   = req_ch.byte_addr;
      req_pl.byte_in     = req_ch.byte_in;
      req_pl.entry_index = req_ch.entry_index;
      req_pl.entry_in    = req_ch.entry_in;
   end
   assign req_ch.ready = req_ready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= fat12te_pkg::ENTRIES_RESET;
      end else if (csr_we) begin
         entries_ff <= csr_wdata;
      end
   end

   fat12te_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .TABLE_BYTES (TABLE_BYTES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ready),
      .req_pl         (req_pl),
      .entries_in_use (entries_ff),
      .out_free       (out_free),
      .res_valid      (res_valid),
      .res            (res),
      .mem_req        (mem_req),
      .mem_rd_data    (mem_rd_data)
   );

   fat12te_mem #(
      .DEPTH (TABLE_BYTES)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_pl_ff <= res;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.entry_out   = rsp_pl_ff.entry_out;
   assign rsp_ch.byte_out    = rsp_pl_ff.byte_out;
   assign rsp_ch.free_index  = rsp_pl_ff.free_index;
   assign rsp_ch.free_found  = rsp_pl_ff.free_found;
   assign rsp_ch.free_bytes  = rsp_pl_ff.free_bytes;
   assign rsp_ch.range_error = rsp_pl_ff.range_error;

endmodule

// File: rtl/core/fat12te_mem.sv
// Byte store of the packed allocation table: one write port, one registered read port.
// Depends on fat12te_pkg (mem_req_type).
module fat12te_mem #(
   parameter int DEPTH = 6144
) (
   input  logic                            clock,
   input  fat12te_pkg::mem_req_type        mem_req,
   output logic [fat12te_pkg::BYTE_W-1:0]  rd_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [fat12te_pkg::BYTE_W-1:0] store [DEPTH];
   logic [fat12te_pkg::BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
   end

   // read port, registered output
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= store[mem_req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fat12te_ctrl.sv
// Request sequencer: byte access, entry read-modify-write and the free-entry scan.
// Drives fat12te_mem through mem_req_type; depends on fat12te_pkg.
module fat12te_ctrl #(
   parameter int MAX_ENTRIES = 4096,
   parameter int TABLE_BYTES = 6144
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  fat12te_pkg::req_payload_type     req_pl,
   input  logic [fat12te_pkg::CNT_W-1:0]    entries_in_use,
   input  logic                             out_free,
   output logic                             res_valid,
   output fat12te_pkg::rsp_payload_type     res,
   output fat12te_pkg::mem_req_type         mem_req,
   input  logic [fat12te_pkg::BYTE_W-1:0]   mem_rd_data
);
   // entries whose second byte still lies inside the table
   localparam int FIT_RAW     = (2 * (TABLE_BYTES - 2) + 1) / 3 + 1;
   localparam int FIT_ENTRIES = (FIT_RAW < MAX_ENTRIES) ? FIT_RAW : MAX_ENTRIES;
   localparam logic [fat12te_pkg::CNT_W-1:0]  FIT_N   = fat12te_pkg::CNT_W'(FIT_ENTRIES);
   localparam logic [fat12te_pkg::ADDR_W-1:0] BYTES_N = fat12te_pkg::ADDR_W'(TABLE_BYTES);

   // sequencer states
   typedef enum logic [7:0] {
      S_IDLE    = 8'b00000001,
      S_RD_BYTE = 8'b00000010,
      S_GET_LO  = 8'b00000100,
      S_GET_HI  = 8'b00001000,
      S_SET_RD  = 8'b00010000,
      S_SET_WR  = 8'b00100000,
      S_SCAN    = 8'b01000000,
      S_FIN     = 8'b10000000
   } seq_state_type;

   seq_state_type                      state_ff, state_in;
   logic [fat12te_pkg::REQ_W-1:0]      op_ff, op_in;
   logic                               odd_ff, odd_in;
   logic [fat12te_pkg::ADDR_W-1:0]     kaddr_ff, kaddr_in;
   logic [fat12te_pkg::IDX_W-1:0]      val_ff, val_in;
   logic [fat12te_pkg::BYTE_W-1:0]     lo_ff, lo_in;
   logic [fat12te_pkg::BYTE_W-1:0]     wr_byte_ff, wr_byte_in;
   logic [fat12te_pkg::ADDR_W-1:0]     issue_ff, issue_in;
   logic [1:0]                         phase_ff, phase_in;
   logic [fat12te_pkg::CNT_W-1:0]      ent_ff, ent_in;
   logic [fat12te_pkg::CNT_W-1:0]      zcnt_ff, zcnt_in;
   logic [fat12te_pkg::CNT_W-1:0]      limit_ff, limit_in;
   fat12te_pkg::rsp_payload_type       res_ff, res_in;

   logic                               accept;
   logic [fat12te_pkg::ADDR_W-1:0]     k_new;
   logic                               addr_ok;
   logic                               idx_ok;
   logic [fat12te_pkg::IDX_W-1:0]      scan_val;
   logic                               scan_zero;
   logic [fat12te_pkg::CNT_W-1:0]      ent_next;
   logic [fat12te_pkg::CNT_W-1:0]      zcnt_next;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign res       = res_ff;
   assign res_valid = (state_ff == S_FIN) && out_free;

   // first byte of entry e sits at e + e/2
   assign k_new   = {1'b0, req_pl.entry_index}
                  + {2'b00, req_pl.entry_index[fat12te_pkg::IDX_W-1:1]};
   assign addr_ok = (req_pl.byte_addr < BYTES_N);
   assign idx_ok  = ({1'b0, req_pl.entry_index} < FIT_N);

   // scan: entry completes on the second and third byte of each group of three
   assign scan_val  = (phase_ff == 2'd1) ? {mem_rd_data[3:0], lo_ff}
                                         : {mem_rd_data, lo_ff[7:4]};
   assign scan_zero = (scan_val == '0);
   assign ent_next  = ent_ff + 1'b1;
   assign zcnt_next = zcnt_ff + fat12te_pkg::CNT_W'(scan_zero);

   // sequencer; writes always finish before the next request is taken,
   // so no read can meet a write to the same byte in flight
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      odd_in     = odd_ff;
      kaddr_in   = kaddr_ff;
      val_in     = val_ff;
      lo_in      = lo_ff;
      wr_byte_in = wr_byte_ff;
      issue_in   = issue_ff;
      phase_in   = phase_ff;
      ent_in     = ent_ff;
      zcnt_in    = zcnt_ff;
      limit_in   = limit_ff;
      res_in     = res_ff;
      mem_req    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_pl.req_type;
               odd_in   = req_pl.entry_index[0];
               kaddr_in = k_new;
               val_in   = req_pl.entry_in;
               res_in   = '0;
               state_in = S_FIN;
               case (req_pl.req_type)
                  fat12te_pkg::REQ_LOAD: begin
                     if (addr_ok) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = req_pl.byte_addr;
                        mem_req.wr_data = req_pl.byte_in;
                     end else begin
                        res_in.range_error = 1'b1;
                     end
                  end
                  fat12te_pkg::REQ_READ: begin
                     if (addr_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_pl.byte_addr;
                        state_in        = S_RD_BYTE;
                     end else begin
                        res_in.range_error = 1'b1;
                     end
                  end
                  fat12te_pkg::REQ_GET: begin
                     if (idx_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = k_new;
                        state_in        = S_GET_LO;
                     end else begin
                        res_in.range_error = 1'b1;
                     end
                  end
                  fat12te_pkg::REQ_SET: begin
                     // only the byte shared with the neighbor needs reading
                     if (idx_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_pl.entry_index[0] ? k_new : k_new + 1'b1;
                        state_in        = S_SET_RD;
                     end else begin
                        res_in.range_error = 1'b1;
                     end
                  end
                  fat12te_pkg::REQ_FIND, fat12te_pkg::REQ_COUNT: begin
                     limit_in = (entries_in_use < FIT_N) ? entries_in_use : FIT_N;
                     issue_in = fat12te_pkg::ADDR_W'(1);
                     phase_in = 2'd0;
                     ent_in   = '0;
                     zcnt_in  = '0;
                     if ((entries_in_use != '0) && (FIT_N != '0)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        state_in        = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_RD_BYTE: begin
            res_in.byte_out = mem_rd_data;
            state_in        = S_FIN;
         end

         S_GET_LO: begin
            lo_in           = mem_rd_data;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = kaddr_ff + 1'b1;
            state_in        = S_GET_HI;
         end

         S_GET_HI: begin
            res_in.entry_out = odd_ff ? {mem_rd_data, lo_ff[7:4]}
                                      : {mem_rd_data[3:0], lo_ff};
            state_in         = S_FIN;
         end

         S_SET_RD: begin
            // first byte now, second byte next cycle
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = kaddr_ff;
            if (odd_ff) begin
               mem_req.wr_data = {val_ff[3:0], mem_rd_data[3:0]};
               wr_byte_in      = val_ff[11:4];
            end else begin
               mem_req.wr_data = val_ff[7:0];
               wr_byte_in      = (mem_rd_data & fat12te_pkg::HI_NIBBLE)
                               | {4'h0, val_ff[11:8]};
            end
            state_in = S_SET_WR;
         end

         S_SET_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = kaddr_ff + 1'b1;
            mem_req.wr_data = wr_byte_ff;
            state_in        = S_FIN;
         end

         S_SCAN: begin
            // stream one byte a cycle; reads past the table end are dropped
            mem_req.rd_en   = (issue_ff < BYTES_N);
            mem_req.rd_addr = issue_ff;
            issue_in        = issue_ff + 1'b1;
            lo_in           = mem_rd_data;
            phase_in        = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 1'b1;
            if (phase_ff != 2'd0) begin
               ent_in  = ent_next;
               zcnt_in = zcnt_next;
               if ((op_ff == fat12te_pkg::REQ_FIND) && scan_zero) begin
                  res_in.free_found = 1'b1;
                  res_in.free_index = ent_ff[fat12te_pkg::IDX_W-1:0];
                  state_in          = S_FIN;
               end else if (ent_next == limit_ff) begin
                  if (op_ff == fat12te_pkg::REQ_COUNT) begin
                     res_in.free_bytes = {zcnt_next,
                                          {fat12te_pkg::CLUSTER_SHIFT{1'b0}}};
                  end
                  state_in = S_FIN;
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      odd_ff     <= odd_in;
      kaddr_ff   <= kaddr_in;
      val_ff     <= val_in;
      lo_ff      <= lo_in;
      wr_byte_ff <= wr_byte_in;
      issue_ff   <= issue_in;
      phase_ff   <= phase_in;
      ent_ff     <= ent_in;
      zcnt_ff    <= zcnt_in;
      limit_ff   <= limit_in;
      res_ff     <= res_in;
   end

endmodule

// File: bench/tb_fat12_table_engine_top.sv
// Self-checking bench for fat12_table_engine_top: valid/ready request and response channels.
// Depends on fat12te_pkg and fat12te_if; predicts untyped responses from its table image.
module tb_fat12_table_engine_top;
   import fat12te_pkg::*;

   localparam int MAX_ENTRIES      = 4096;
   localparam int TABLE_BYTES      = 6144;
   localparam int PRELOAD_BYTES    = 384;   // bytes of entries 0..255
   localparam int SCAN_SPAN        = 256;   // entries held in the preloaded bytes
   localparam int ITEMS_PER_PHASE  = 92;
   localparam int PRESSURE_CYCLES  = 400;
   localparam int DRAIN_CYCLES     = 20;
   localparam int unsigned LIMIT_CYCLES = 2_000_000;

   // request codes the block leaves unused
   localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

   typedef struct packed {
      logic               is_csr;
      logic [CNT_W-1:0]   csr_value;
      req_payload_type    req;
      logic               typed;
      rsp_payload_type    rsp;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CNT_W-1:0] csr_wdata;

   fat12te_req_if req_ch ();
   fat12te_rsp_if rsp_ch ();

   fat12_table_engine_top #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .TABLE_BYTES(TABLE_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // mirror of the packed table and the entries_in_use register
   logic [BYTE_W-1:0] fat_image [TABLE_BYTES];
   int unsigned       scan_limit;
   logic [IDX_W-1:0]  hot_entry;

   rsp_payload_type pending_rsp [$];
   dir_row_type     dir_rows [$];

   int gap_max;
   int fail_count;
   int rsp_total;
   int pressure_at;
   int csr_writes;
   int range_errors;
   int free_hits;
   int req_hist [8];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic bit entry_fits(input int unsigned e);
      if (e >= MAX_ENTRIES) return 1'b0;
      return ((3 * e) >> 1) + 1 < TABLE_BYTES;
   endfunction

   function automatic logic [IDX_W-1:0] entry_value(input int unsigned e);
      int unsigned k;
      k = (3 * e) >> 1;
      if (e[0] == 1'b0) return {fat_image[k+1][3:0], fat_image[k]};
      return {fat_image[k+1], fat_image[k][7:4]};
   endfunction

   // a set keeps the neighbor's nibble in the shared byte
   function automatic void store_entry(input int unsigned e, input logic [IDX_W-1:0] v);
      int unsigned k;
      k = (3 * e) >> 1;
      if (e[0] == 1'b0) begin
         fat_image[k]   = v[7:0];
         fat_image[k+1] = {fat_image[k+1][7:4], v[11:8]};
      end else begin
         fat_image[k]   = {v[3:0], fat_image[k][3:0]};
         fat_image[k+1] = v[11:4];
      end
   endfunction

   function automatic rsp_payload_type predict_table(input req_payload_type r);
      rsp_payload_type o;
      int unsigned     e;
      int unsigned     zeros;
      o = '0;
      case (r.req_type)
         REQ_LOAD: begin
            if (r.byte_addr < TABLE_BYTES) fat_image[r.byte_addr] = r.byte_in;
            else o.range_error = 1'b1;
         end
         REQ_READ: begin
            if (r.byte_addr < TABLE_BYTES) o.byte_out = fat_image[r.byte_addr];
            else o.range_error = 1'b1;
         end
         REQ_GET: begin
            if (entry_fits(r.entry_index)) o.entry_out = entry_value(r.entry_index);
            else o.range_error = 1'b1;
         end
         REQ_SET: begin
            if (entry_fits(r.entry_index)) store_entry(r.entry_index, r.entry_in);
            else o.range_error = 1'b1;
         end
         REQ_FIND: begin
            for (e = 0; e < scan_limit && entry_fits(e); e++) begin
               if (entry_value(e) == '0) begin
                  o.free_index = IDX_W'(e);
                  o.free_found = 1'b1;
                  break;
               end
            end
         end
         REQ_COUNT: begin
            zeros = 0;
            for (e = 0; e < scan_limit && entry_fits(e); e++)
               if (entry_value(e) == '0) zeros++;
            o.free_bytes = FREE_W'(zeros << CLUSTER_SHIFT);
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic req_payload_type rq(input logic [REQ_W-1:0] code,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [BYTE_W-1:0] bin,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [IDX_W-1:0] ein);
      req_payload_type r;
      r.req_type    = code;
      r.byte_addr   = addr;
      r.byte_in     = bin;
      r.entry_index = idx;
      r.entry_in    = ein;
      return r;
   endfunction

   function automatic rsp_payload_type rs(input logic [IDX_W-1:0] eo,
                                          input logic [BYTE_W-1:0] bo,
                                          input logic [IDX_W-1:0] fi,
                                          input logic ff,
                                          input logic [FREE_W-1:0] fb,
                                          input logic err);
      rsp_payload_type o;
      o.entry_out   = eo;
      o.byte_out    = bo;
      o.free_index  = fi;
      o.free_found  = ff;
      o.free_bytes  = fb;
      o.range_error = err;
      return o;
   endfunction

   // random request: mostly inside the scanned region and near the last set entry;
   // reads, gets and sets stay on bytes that hold loaded data
   function automatic req_payload_type draw_request();
      req_payload_type r;
      int unsigned     span;
      int unsigned     pick;
      int unsigned     roll;
      span = (scan_limit > MAX_ENTRIES) ? MAX_ENTRIES : scan_limit;
      r.byte_addr   = ADDR_W'($urandom);
      r.byte_in     = BYTE_W'($urandom);
      r.entry_index = IDX_W'($urandom);
      r.entry_in    = IDX_W'($urandom);
      pick = $urandom_range(99, 0);
      roll = $urandom_range(99, 0);

      if (pick < 18)      r.req_type = REQ_LOAD;
      else if (pick < 33) r.req_type = REQ_READ;
      else if (pick < 53) r.req_type = REQ_GET;
      else if (pick < 80) r.req_type = REQ_SET;
      else if (pick < 98) begin
         // long scans are slow, so keep them rare
         if (span > 512 && $urandom_range(7, 0) != 0) r.req_type = REQ_GET;
         else r.req_type = (pick < 89) ? REQ_FIND : REQ_COUNT;
      end else begin
         r.req_type = $urandom_range(1, 0) ? REQ_SPARE_6 : REQ_SPARE_7;
      end

      case (r.req_type)
         REQ_LOAD, REQ_READ: begin
            if (roll < 10)
               r.byte_addr = ADDR_W'($urandom_range(8191, TABLE_BYTES));
            else if (roll < 55 || r.req_type == REQ_READ)
               r.byte_addr = ADDR_W'($urandom_range(PRELOAD_BYTES - 1, 0));
            else
               r.byte_addr = ADDR_W'($urandom_range(TABLE_BYTES - 1, 0));
            if (r.req_type == REQ_LOAD && $urandom_range(3, 0) == 0) r.byte_in = '0;
         end
         REQ_GET, REQ_SET: begin
            if (roll < 40)
               r.entry_index = hot_entry + IDX_W'($urandom_range(3, 0)) - IDX_W'(1);
            else if (roll < 75)
               r.entry_index = IDX_W'($urandom_range((span == 0) ? 0 : span - 1, 0));
            // only the preloaded entries and the two loaded at the table end
            if (r.entry_index >= SCAN_SPAN && r.entry_index < MAX_ENTRIES - 2)
               r.entry_index = IDX_W'(r.entry_index % SCAN_SPAN);
            if (r.req_type == REQ_SET) begin
               case ($urandom_range(9, 0))
                  0, 1, 2: r.entry_in = '0;
                  3:       r.entry_in = '1;
                  default: ;
               endcase
               hot_entry = r.entry_index;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- request side
   // Leaves valid high on return; the next call or settle() decides what follows.
   task automatic offer(input req_payload_type item, input bit typed,
                        input rsp_payload_type typed_rsp);
      int              gap;
      rsp_payload_type predicted;
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= item.req_type;
      req_ch.byte_addr   <= item.byte_addr;
      req_ch.byte_in     <= item.byte_in;
      req_ch.entry_index <= item.entry_index;
      req_ch.entry_in    <= item.entry_in;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // transfer at this edge
      predicted = predict_table(item);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      req_hist[item.req_type]++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_scan_limit(input int unsigned v);
      csr_we    <= 1'b1;
      csr_wdata <= CNT_W'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
      scan_limit = v & 32'h1FFF;
      csr_writes++;
   endtask

   // ---------------------------------------------------------------- response side
   task automatic match_field(input string name, input logic [FREE_W-1:0] want,
                              input logic [FREE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   initial begin : response_side
      int              stall;
      rsp_payload_type want;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // one long hold-off lets the block fill and stall its input
         stall = (rsp_total == pressure_at) ? PRESSURE_CYCLES : $urandom_range(gap_max, 0);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         rsp_total++;
         if (rsp_ch.range_error === 1'b1) range_errors++;
         if (rsp_ch.free_found === 1'b1) free_hits++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing outstanding, entry 0x%0h byte 0x%0h",
                     $time, rsp_ch.entry_out, rsp_ch.byte_out);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            match_field("entry_out",   FREE_W'(want.entry_out),   FREE_W'(rsp_ch.entry_out));
            match_field("byte_out",    FREE_W'(want.byte_out),    FREE_W'(rsp_ch.byte_out));
            match_field("free_index",  FREE_W'(want.free_index),  FREE_W'(rsp_ch.free_index));
            match_field("free_found",  FREE_W'(want.free_found),  FREE_W'(rsp_ch.free_found));
            match_field("free_bytes",  want.free_bytes,           rsp_ch.free_bytes);
            match_field("range_error", FREE_W'(want.range_error), FREE_W'(rsp_ch.range_error));
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles, %0d responses outstanding", cycles,
               pending_rsp.size());
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence
   initial begin : stimulus
      int unsigned     phase_limit [8];
      int              dir_reqs;
      int              p;
      int              i;
      int              a;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = '0;
      req_ch.byte_addr   = '0;
      req_ch.byte_in     = '0;
      req_ch.entry_index = '0;
      req_ch.entry_in    = '0;
      gap_max      = 13;
      fail_count   = 0;
      rsp_total    = 0;
      csr_writes   = 0;
      range_errors = 0;
      free_hits    = 0;
      hot_entry    = '0;
      scan_limit   = ENTRIES_RESET;
      pressure_at  = -1;
      foreach (req_hist[k]) req_hist[k] = 0;
      foreach (fat_image[k]) fat_image[k] = '0;

      // directed table; typed responses assume the all-zero preload
      // a find at the reset length stops on entry 0
      dir_rows.push_back('{1'b0, '0, rq(REQ_FIND, '0, '0, '0, '0),
                           1'b1, rs('0, '0, '0, 1'b1, '0, 1'b0)});
      dir_rows.push_back('{1'b1, CNT_W'(SCAN_SPAN), '0, 1'b0, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_COUNT, '0, '0, '0, '0),
                           1'b1, rs('0, '0, '0, 1'b0, FREE_W'(SCAN_SPAN * 512), 1'b0)});
      // largest scan length
      dir_rows.push_back('{1'b1, 13'd8191, '0, 1'b0, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_FIND, '1, '1, '1, '1),
                           1'b1, rs('0, '0, '0, 1'b1, '0, 1'b0)});
      // empty scan
      dir_rows.push_back('{1'b1, 13'd0, '0, 1'b0, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_FIND, '0, '0, '0, '0), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_COUNT, '0, '0, '0, '0), 1'b1, '0});
      dir_rows.push_back('{1'b1, 13'd1, '0, 1'b0, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_COUNT, '0, '0, '0, '0),
                           1'b1, rs('0, '0, '0, 1'b0, FREE_W'(512), 1'b0)});
      dir_rows.push_back('{1'b1, CNT_W'(SCAN_SPAN), '0, 1'b0, '0});
      // byte edges and out-of-range addresses
      dir_rows.push_back('{1'b0, '0, rq(REQ_LOAD, 13'd6141, 8'h00, '0, '0), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_LOAD, 13'd6142, 8'h00, '0, '0), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_LOAD, 13'd6143, 8'hFF, '0, '0), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_READ, 13'd6143, '0, '0, '0),
                           1'b1, rs('0, 8'hFF, '0, 1'b0, '0, 1'b0)});
      dir_rows.push_back('{1'b0, '0, rq(REQ_LOAD, 13'd6144, 8'h5A, '0, '0),
                           1'b1, rs('0, '0, '0, 1'b0, '0, 1'b1)});
      dir_rows.push_back('{1'b0, '0, rq(REQ_READ, 13'd8191, '0, '0, '0),
                           1'b1, rs('0, '0, '0, 1'b0, '0, 1'b1)});
      // entries sharing a byte stay independent
      dir_rows.push_back('{1'b0, '0, rq(REQ_SET, '0, '0, 12'd0, 12'hFFF), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_GET, '0, '0, 12'd0, '0),
                           1'b1, rs(12'hFFF, '0, '0, 1'b0, '0, 1'b0)});
      dir_rows.push_back('{1'b0, '0, rq(REQ_GET, '0, '0, 12'd1, '0), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_SET, '0, '0, 12'd1, 12'hFFF), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_FIND, '0, '0, '0, '0),
                           1'b1, rs('0, '0, 12'd2, 1'b1, '0, 1'b0)});
      dir_rows.push_back('{1'b0, '0, rq(REQ_SET, '0, '0, 12'd4095, 12'hABC), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_GET, '0, '0, 12'd4095, '0),
                           1'b1, rs(12'hABC, '0, '0, 1'b0, '0, 1'b0)});
      dir_rows.push_back('{1'b0, '0, rq(REQ_SET, '0, '0, 12'd4094, 12'h123), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_GET, '0, '0, 12'd4094, '0),
                           1'b1, rs(12'h123, '0, '0, 1'b0, '0, 1'b0)});
      dir_rows.push_back('{1'b0, '0, rq(REQ_GET, '0, '0, 12'd4095, '0),
                           1'b1, rs(12'hABC, '0, '0, 1'b0, '0, 1'b0)});
      dir_rows.push_back('{1'b0, '0, rq(REQ_SET, '0, '0, 12'd2, 12'h800), 1'b0, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_COUNT, '0, '0, '0, '0), 1'b0, '0});
      // unused codes answer with all fields clear
      dir_rows.push_back('{1'b0, '0, rq(REQ_SPARE_6, '1, '1, '1, '1), 1'b1, '0});
      dir_rows.push_back('{1'b0, '0, rq(REQ_SPARE_7, '1, '1, '1, '1), 1'b1, '0});

      dir_reqs = 0;
      foreach (dir_rows[k]) if (!dir_rows[k].is_csr) dir_reqs++;
      pressure_at = PRELOAD_BYTES + dir_reqs + 60;

      // scan lengths stay inside the preloaded entries
      phase_limit = '{2, SCAN_SPAN, 37, SCAN_SPAN - 1, 1, 200, 0, 131};
      phase_limit[6] = $urandom_range(64, 3);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // preload the scanned region with zero so no checked result depends on an unwritten byte
      for (a = 0; a < PRELOAD_BYTES; a++)
         offer(rq(REQ_LOAD, ADDR_W'(a), '0, IDX_W'($urandom), IDX_W'($urandom)), 1'b0, '0);

      foreach (dir_rows[k]) begin
         if (dir_rows[k].is_csr) begin
            settle();
            write_scan_limit(dir_rows[k].csr_value);
         end else begin
            offer(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp);
         end
      end
      settle();

      // random phases, two of them back to back with no idle cycles
      for (p = 0; p < 8; p++) begin
         write_scan_limit(phase_limit[p]);
         gap_max = (p == 2 || p == 5) ? 0 : 13;
         for (i = 0; i < ITEMS_PER_PHASE; i++)
            offer(draw_request(), 1'b0, '0);
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d loads, %0d byte reads, %0d gets, %0d sets, %0d finds, %0d counts,",
               req_hist[REQ_LOAD], req_hist[REQ_READ], req_hist[REQ_GET], req_hist[REQ_SET],
               req_hist[REQ_FIND], req_hist[REQ_COUNT]);
      $display("%0d unused codes, %0d register writes, %0d range errors, %0d free hits, %0d errors",
               req_hist[REQ_SPARE_6] + req_hist[REQ_SPARE_7], csr_writes, range_errors,
               free_hits, fail_count);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/fat12te_pkg.sv
rtl/core/fat12te_if.sv
rtl/core/fat12te_mem.sv
rtl/core/fat12te_ctrl.sv
rtl/core/fat12_table_engine_top.sv
bench/tb_fat12_table_engine_top.sv
